[rtl/core/indexed_deque_engine_core_macros.svh]
// Assertion macros used by the indexed deque engine checker.
`ifndef INDEXED_DEQUE_ENGINE_CORE_MACROS_SVH
`define INDEXED_DEQUE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IDEC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("idec check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IDEC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("idec check failed");

`endif

[rtl/core/idec_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the indexed deque engine.
package idec_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TYPE_W = 4;
	localparam int POS_W  = 5;
	localparam int POS2_W = 4;
	localparam int STAT_W = 2;

	typedef enum logic [TYPE_W-1:0] {
		OP_PUSH_TAIL = 4'd0,
		OP_PUSH_HEAD = 4'd1,
		OP_POP       = 4'd2,
		OP_PEEK      = 4'd3,
		OP_READ      = 4'd4,
		OP_INSERT    = 4'd5,
		OP_REMOVE    = 4'd6,
		OP_SWAP      = 4'd7,
		OP_TRUNC     = 4'd8
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef enum logic {
		CS_IDLE,
		CS_SWAP
	} ctrl_state_t;

	typedef struct packed {
		logic exec;
		logic swap_fin;
	} idec_cmd_t;

	typedef struct packed {
		logic swap_go;
	} idec_sts_t;

endpackage

[rtl/core/idec_ctrl.sv]
`timescale 1ns / 1ps
// Request sequencer of the indexed deque engine.
module idec_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  idec_pkg::idec_sts_t   sts,
	output idec_pkg::idec_cmd_t   cmd,
	output logic                  busy
);

	idec_pkg::ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idec_pkg::CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		cmd.exec     = 1'b0;
		cmd.swap_fin = 1'b0;
		busy         = 1'b0;
		unique case (state_q)
			idec_pkg::CS_IDLE: begin
				cmd.exec = start;
				if (start && sts.swap_go) begin
					state_nxt = idec_pkg::CS_SWAP;
				end
			end
			idec_pkg::CS_SWAP: begin
				busy         = 1'b1;
				cmd.swap_fin = 1'b1;
				state_nxt    = idec_pkg::CS_IDLE;
			end
			default: begin
				state_nxt = idec_pkg::CS_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/idec_dp.sv]
`timescale 1ns / 1ps
// Entry cells, count and result registers of the indexed deque engine.
module idec_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  idec_pkg::idec_cmd_t           cmd,
	output idec_pkg::idec_sts_t           sts,
	input  logic [idec_pkg::TYPE_W-1:0]   req_type,
	input  logic [idec_pkg::POS_W-1:0]    position,
	input  logic [idec_pkg::POS2_W-1:0]   other_position,
	input  logic [idec_pkg::DATA_W-1:0]   data_in,
	output logic                          done,
	output logic [idec_pkg::DATA_W-1:0]   data_out,
	output logic [idec_pkg::STAT_W-1:0]   status,
	output logic [idec_pkg::CNT_W-1:0]    entry_count
);

	logic [idec_pkg::DATA_W-1:0] cells_q [idec_pkg::DEPTH];
	logic [idec_pkg::CNT_W-1:0]  cnt_q, cnt_nxt;
	logic [idec_pkg::DATA_W-1:0] tmp_q;
	logic [idec_pkg::IDX_W-1:0]  swp_a_q, swp_b_q;
	logic                        done_q;
	logic [idec_pkg::DATA_W-1:0] data_q, res_data;
	logic [idec_pkg::STAT_W-1:0] status_q, res_status;

	logic                        full, empty, pos_ok, pos2_ok, op_ok;
	logic [idec_pkg::IDX_W-1:0]  pidx;

	assign full    = (cnt_q == idec_pkg::CNT_W'(idec_pkg::DEPTH));
	assign empty   = (cnt_q == '0);
	assign pos_ok  = (position < cnt_q);
	assign pos2_ok = ({1'b0, other_position} < cnt_q);
	assign pidx    = position[idec_pkg::IDX_W-1:0];

	always_comb begin
		op_ok      = 1'b0;
		res_status = idec_pkg::ST_OK;
		res_data   = '0;
		cnt_nxt    = cnt_q;
		unique case (req_type)
			idec_pkg::OP_PUSH_TAIL, idec_pkg::OP_PUSH_HEAD: begin
				op_ok = !full;
				if (full) res_status = idec_pkg::ST_FULL;
				else cnt_nxt = cnt_q + idec_pkg::CNT_W'(1);
			end
			idec_pkg::OP_POP: begin
				op_ok = !empty;
				if (empty) begin
					res_status = idec_pkg::ST_BAD;
				end else begin
					res_data = cells_q[0];
					cnt_nxt  = cnt_q - idec_pkg::CNT_W'(1);
				end
			end
			idec_pkg::OP_PEEK: begin
				op_ok = !empty;
				if (empty) res_status = idec_pkg::ST_BAD;
				else res_data = cells_q[0];
			end
			idec_pkg::OP_READ: begin
				op_ok = pos_ok;
				if (!pos_ok) res_status = idec_pkg::ST_BAD;
				else res_data = cells_q[pidx];
			end
			idec_pkg::OP_INSERT: begin
				op_ok = pos_ok && !full;
				if (!pos_ok) res_status = idec_pkg::ST_BAD;
				else if (full) res_status = idec_pkg::ST_FULL;
				else cnt_nxt = cnt_q + idec_pkg::CNT_W'(1);
			end
			idec_pkg::OP_REMOVE: begin
				op_ok = pos_ok;
				if (!pos_ok) begin
					res_status = idec_pkg::ST_BAD;
				end else begin
					res_data = cells_q[pidx];
					cnt_nxt  = cnt_q - idec_pkg::CNT_W'(1);
				end
			end
			idec_pkg::OP_SWAP: begin
				op_ok = pos_ok && pos2_ok;
				if (!op_ok) res_status = idec_pkg::ST_BAD;
			end
			idec_pkg::OP_TRUNC: begin
				op_ok = 1'b1;
				if (pos_ok) cnt_nxt = position;
			end
			default: begin
				res_status = idec_pkg::ST_BAD;
			end
		endcase
	end

	assign sts.swap_go = (req_type == idec_pkg::OP_SWAP) && op_ok;

	// entry cells: shifts for head ops, insert and remove; two-step swap via tmp_q
	always_ff @(posedge clk) begin
		if (cmd.exec && op_ok) begin
			unique case (req_type)
				idec_pkg::OP_PUSH_TAIL: begin
					cells_q[cnt_q[idec_pkg::IDX_W-1:0]] <= data_in;
				end
				idec_pkg::OP_PUSH_HEAD: begin
					cells_q[0] <= data_in;
					for (int i = 1; i < idec_pkg::DEPTH; i++) begin
						cells_q[i] <= cells_q[i-1];
					end
				end
				idec_pkg::OP_POP: begin
					for (int i = 0; i < idec_pkg::DEPTH - 1; i++) begin
						cells_q[i] <= cells_q[i+1];
					end
				end
				idec_pkg::OP_INSERT: begin
					if (pidx == '0) cells_q[0] <= data_in;
					for (int i = 1; i < idec_pkg::DEPTH; i++) begin
						if (idec_pkg::IDX_W'(i) > pidx) cells_q[i] <= cells_q[i-1];
						else if (idec_pkg::IDX_W'(i) == pidx) cells_q[i] <= data_in;
					end
				end
				idec_pkg::OP_REMOVE: begin
					for (int i = 0; i < idec_pkg::DEPTH - 1; i++) begin
						if (idec_pkg::IDX_W'(i) >= pidx) cells_q[i] <= cells_q[i+1];
					end
				end
				idec_pkg::OP_SWAP: begin
					tmp_q   <= cells_q[pidx];
					swp_a_q <= pidx;
					swp_b_q <= other_position[idec_pkg::IDX_W-1:0];
				end
				default: ;
			endcase
		end else if (cmd.swap_fin) begin
			for (int i = 0; i < idec_pkg::DEPTH; i++) begin
				if (idec_pkg::IDX_W'(i) == swp_b_q) cells_q[i] <= tmp_q;
				else if (idec_pkg::IDX_W'(i) == swp_a_q) cells_q[i] <= cells_q[swp_b_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.exec && !sts.swap_go) || cmd.swap_fin;
			if (cmd.exec) cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.swap_fin) begin
			data_q   <= '0;
			status_q <= idec_pkg::ST_OK;
		end else if (cmd.exec) begin
			data_q   <= res_data;
			status_q <= res_status;
		end
	end

	assign done        = done_q;
	assign data_out    = data_q;
	assign status      = status_q;
	assign entry_count = cnt_q;

endmodule

[rtl/core/indexed_deque_engine_core.sv]
`timescale 1ns / 1ps
// Top level of the indexed deque engine.
// A request is taken when start is high and busy is low. Every request other
// than a swap of two valid indices is finished when taken; such a swap adds
// the write-back state CS_SWAP, in which busy is high while the held entry
// is written back to the cell row. Each request gives one result word: done
// pulses for exactly one cycle, the cycle after the request finishes, with
// data_out, status and entry_count valid during it. The receiver cannot
// stall; a result not taken in its done cycle is gone. A new request may be
// taken in the same cycle as the previous done pulse.
module indexed_deque_engine_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [idec_pkg::TYPE_W-1:0]   req_type,
	input  logic [idec_pkg::POS_W-1:0]    position,
	input  logic [idec_pkg::POS2_W-1:0]   other_position,
	input  logic [idec_pkg::DATA_W-1:0]   data_in,
	output logic                          done,
	output logic [idec_pkg::DATA_W-1:0]   data_out,
	output logic [idec_pkg::STAT_W-1:0]   status,
	output logic [idec_pkg::CNT_W-1:0]    entry_count
);

	idec_pkg::idec_cmd_t cmd;
	idec_pkg::idec_sts_t sts;

	idec_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	idec_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.position       (position),
		.other_position (other_position),
		.data_in        (data_in),
		.done           (done),
		.data_out       (data_out),
		.status         (status),
		.entry_count    (entry_count)
	);

endmodule

[rtl/core/idec_chk.sv]
`timescale 1ns / 1ps
// Port-level checker of the indexed deque engine, bound to the top level.
`include "indexed_deque_engine_core_macros.svh"

module idec_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [idec_pkg::TYPE_W-1:0]   req_type,
	input logic                          done,
	input logic [idec_pkg::DATA_W-1:0]   data_out,
	input logic [idec_pkg::STAT_W-1:0]   status,
	input logic [idec_pkg::CNT_W-1:0]    entry_count
);

	`IDEC_ASSERT_NOW(a_count_range, done, entry_count <= idec_pkg::CNT_W'(idec_pkg::DEPTH))
	`IDEC_ASSERT_NOW(a_status_code, done, status <= idec_pkg::ST_FULL)
	`IDEC_ASSERT_NOW(a_fail_zero, done && status != idec_pkg::ST_OK, data_out == '0)
	`IDEC_ASSERT_NEXT(a_single_done, start && !busy && req_type != idec_pkg::OP_SWAP, done && !busy)
	`IDEC_ASSERT_NEXT(a_swap_step, busy, done && !busy)

endmodule

bind indexed_deque_engine_core idec_chk u_idec_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.req_type    (req_type),
	.done        (done),
	.data_out    (data_out),
	.status      (status),
	.entry_count (entry_count)
);
